### rtl/vtts_pkg.sv
// shared types and constants for the timed valve toggle sequencer
`default_nettype none

package vtts_pkg;

  localparam int unsigned VALVE_COUNT = 7;
  localparam int unsigned LIST_DEPTH  = 1024;
  localparam int unsigned TIME_W      = 16;
  localparam int unsigned ELAPSED_W   = 32;

  localparam int unsigned V_W    = (VALVE_COUNT > 1) ? $clog2(VALVE_COUNT) : 1;
  localparam int unsigned PTR_W  = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = VALVE_COUNT * LIST_DEPTH;
  localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);

  // valve four is normally open, its pin level is inverted
  localparam logic [VALVE_COUNT-1:0] NO_VALVE_MASK = VALVE_COUNT'(32'h10);

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_CLEAR   = 3'd1,
    CMD_APPEND  = 3'd2,
    CMD_START   = 3'd3,
    CMD_ESTOP   = 3'd4,
    CMD_SET     = 3'd5,
    CMD_IGN_ON  = 3'd6,
    CMD_IGN_OFF = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_TEST,
    S_FIN
  } seq_state_e;

  typedef struct packed {
    logic           clear;
    logic           inc_cnt;
    logic           inc_rp;
    logic [V_W-1:0] idx;
  } ptr_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] rp;
    logic [CNT_W-1:0] cnt;
    logic             live;
    logic             full;
  } ptr_stat_t;

  function automatic logic [ADDR_W-1:0] list_addr(logic [V_W-1:0] v, logic [CNT_W-1:0] p);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(v) * ADDR_W'(LIST_DEPTH);
    return base + ADDR_W'(p[PTR_W-1:0]);
  endfunction

endpackage

`default_nettype wire

### rtl/vtts_list_mem.sv
// toggle time store, one write port and one registered read port
`default_nettype none

module vtts_list_mem
  import vtts_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [TIME_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [TIME_W-1:0] rdata_o
);

  logic [TIME_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/vtts_ptr_table.sv
// per valve read pointers and entry counts
`default_nettype none

module vtts_ptr_table
  import vtts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ptr_ctl_t  ctl_i,
  output ptr_stat_t      stat_o
);

  logic [CNT_W-1:0] rp_q  [VALVE_COUNT];
  logic [CNT_W-1:0] cnt_q [VALVE_COUNT];
  logic             idx_ok;

  assign idx_ok = (32'(ctl_i.idx) < VALVE_COUNT);

  always_comb begin
    stat_o.rp  = idx_ok ? rp_q[ctl_i.idx]  : '0;
    stat_o.cnt = idx_ok ? cnt_q[ctl_i.idx] : '0;
    stat_o.live = (stat_o.rp < stat_o.cnt);
    stat_o.full = (stat_o.cnt >= CNT_W'(LIST_DEPTH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VALVE_COUNT; i++) begin
        rp_q[i]  <= '0;
        cnt_q[i] <= '0;
      end
    end else if (ctl_i.clear) begin
      for (int i = 0; i < VALVE_COUNT; i++) begin
        rp_q[i]  <= '0;
        cnt_q[i] <= '0;
      end
    end else if (idx_ok) begin
      if (ctl_i.inc_cnt) begin
        cnt_q[ctl_i.idx] <= cnt_q[ctl_i.idx] + CNT_W'(1);
      end
      if (ctl_i.inc_rp) begin
        rp_q[ctl_i.idx] <= rp_q[ctl_i.idx] + CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/valve_timed_toggle_sequencer_unit.sv
// top level of the timed valve toggle sequencer
`default_nettype none

// Seven valves, each with a list of toggle times in ms since the run started.
// A command transfer is taken when start_i is high and busy_o is low; its one
// result shows on the result ports for exactly one cycle with valid_o high,
// the cycle after the command finishes, and cannot be held off by the
// receiver. Every command except a tick during a run finishes in its
// accept cycle, so such commands can be issued back to back. A tick during
// a run walks the seven list heads one at a time through the single read
// port of the list memory and one shared time comparator: per valve S_LOOK
// alone when the list is exhausted, S_LOOK then S_TEST when its head is
// live, and S_LOOK, S_TEST, S_LOOK and, if the new head is live, S_TEST when
// the head is popped (the new head is fetched but waits for the next tick),
// then a closing S_FIN state. Appends write the memory in the accept cycle.
// The list memory is not cleared after reset; only written entries are ever
// read. valve_drive_o is valve_state_o with bit four inverted (normally open).

module valve_timed_toggle_sequencer_unit
  import vtts_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [2:0]             command_i,
  input  wire logic [2:0]             valve_index_i,
  input  wire logic [TIME_W-1:0]      entry_time_i,
  input  wire logic [VALVE_COUNT-1:0] valve_pattern_i,
  output logic                        valid_o,
  output logic [VALVE_COUNT-1:0]      valve_state_o,
  output logic [VALVE_COUNT-1:0]      valve_drive_o,
  output logic                        running_o,
  output logic                        igniter_on_o,
  output logic                        sequence_done_o,
  output logic                        status_o
);

  seq_state_e state_q, state_d;

  logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
  logic [VALVE_COUNT-1:0] valves_q, valves_d;
  logic                   run_q, run_d;
  logic                   spark_q, spark_d;
  logic [V_W-1:0]         v_q, v_d;
  logic                   popped_q, popped_d;
  logic                   any_live_q, any_live_d;
  logic                   valid_q, valid_d;
  logic                   done_q, done_d;
  logic                   status_q, status_d;

  logic        accept;
  cmd_e        cmd;
  logic        vi_ok;
  logic        last_valve;
  logic        hit;
  ptr_ctl_t    ptr_ctl;
  ptr_stat_t   ptr_stat;
  logic [TIME_W-1:0] head;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;

  assign busy_o     = (state_q != S_IDLE);
  assign accept     = start_i && !busy_o;
  assign cmd        = cmd_e'(command_i);
  assign vi_ok      = (32'(valve_index_i) < VALVE_COUNT);
  assign last_valve = (v_q == V_W'(VALVE_COUNT - 1));

  // shared comparator: head is live and its time has passed, once per valve
  assign hit = !popped_q && (head != '0) && (elapsed_q > ELAPSED_W'(head));

  assign mem_we    = accept && (cmd == CMD_APPEND) && vi_ok && !ptr_stat.full;
  assign mem_waddr = list_addr(valve_index_i[V_W-1:0], ptr_stat.cnt);
  assign mem_raddr = list_addr(v_q, ptr_stat.rp);

  vtts_ptr_table u_ptr_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ptr_ctl),
    .stat_o (ptr_stat)
  );

  vtts_list_mem u_list_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (entry_time_i),
    .raddr_i (mem_raddr),
    .rdata_o (head)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (cmd == CMD_TICK) && run_q) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (ptr_stat.live) begin
          state_d = S_TEST;
        end else if (last_valve) begin
          state_d = S_FIN;
        end
      end
      S_TEST: begin
        if (hit) begin
          state_d = S_LOOK;
        end else if (last_valve) begin
          state_d = S_FIN;
        end else begin
          state_d = S_LOOK;
        end
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    elapsed_d        = elapsed_q;
    valves_d         = valves_q;
    run_d            = run_q;
    spark_d          = spark_q;
    v_d              = v_q;
    popped_d         = popped_q;
    any_live_d       = any_live_q;
    valid_d          = 1'b0;
    done_d           = 1'b0;
    status_d         = 1'b0;
    ptr_ctl.clear    = 1'b0;
    ptr_ctl.inc_cnt  = 1'b0;
    ptr_ctl.inc_rp   = 1'b0;
    // table index follows the appended valve when idle, the scan counter when busy
    ptr_ctl.idx      = busy_o ? v_q : valve_index_i[V_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          unique case (cmd)
            CMD_TICK: begin
              if (run_q) begin
                // result comes after the scan
                valid_d    = 1'b0;
                elapsed_d  = (elapsed_q == '1) ? elapsed_q : elapsed_q + ELAPSED_W'(1);
                v_d        = '0;
                popped_d   = 1'b0;
                any_live_d = 1'b0;
              end
            end
            CMD_CLEAR: begin
              ptr_ctl.clear = 1'b1;
            end
            CMD_APPEND: begin
              if (vi_ok) begin
                if (ptr_stat.full) begin
                  status_d = 1'b1;
                end else begin
                  ptr_ctl.inc_cnt = 1'b1;
                end
              end
            end
            CMD_START: begin
              run_d     = 1'b1;
              spark_d   = 1'b1;
              elapsed_d = '0;
            end
            CMD_ESTOP: begin
              run_d    = 1'b0;
              spark_d  = 1'b0;
              valves_d = '0;
            end
            CMD_SET: begin
              valves_d = valve_pattern_i;
            end
            CMD_IGN_ON: begin
              spark_d = 1'b1;
            end
            CMD_IGN_OFF: begin
              spark_d = 1'b0;
            end
            default: begin
              spark_d = 1'b0;
            end
          endcase
        end
      end
      S_LOOK: begin
        // exhausted list counts as empty, move on
        if (!ptr_stat.live) begin
          v_d      = last_valve ? '0 : v_q + V_W'(1);
          popped_d = 1'b0;
        end
      end
      S_TEST: begin
        if (hit) begin
          valves_d       = valves_q ^ (VALVE_COUNT'(1) << v_q);
          ptr_ctl.inc_rp = 1'b1;
          popped_d       = 1'b1;
        end else begin
          if (head != '0) begin
            any_live_d = 1'b1;
          end
          v_d      = last_valve ? '0 : v_q + V_W'(1);
          popped_d = 1'b0;
        end
      end
      S_FIN: begin
        valid_d = 1'b1;
        if (!any_live_q) begin
          run_d   = 1'b0;
          spark_d = 1'b0;
          done_d  = 1'b1;
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      elapsed_q  <= '0;
      valves_q   <= '0;
      run_q      <= 1'b0;
      spark_q    <= 1'b0;
      v_q        <= '0;
      popped_q   <= 1'b0;
      any_live_q <= 1'b0;
      valid_q    <= 1'b0;
      done_q     <= 1'b0;
      status_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      elapsed_q  <= elapsed_d;
      valves_q   <= valves_d;
      run_q      <= run_d;
      spark_q    <= spark_d;
      v_q        <= v_d;
      popped_q   <= popped_d;
      any_live_q <= any_live_d;
      valid_q    <= valid_d;
      done_q     <= done_d;
      status_q   <= status_d;
    end
  end

  assign valid_o         = valid_q;
  assign valve_state_o   = valves_q;
  assign valve_drive_o   = valves_q ^ NO_VALVE_MASK;
  assign running_o       = run_q;
  assign igniter_on_o    = spark_q;
  assign sequence_done_o = done_q;
  assign status_o        = status_q;

  // end of run only reported with its result transfer
  a_done_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sequence_done_o |-> valid_o && !running_o && !igniter_on_o)
    else $error("sequence done without result or with run still active");

  // a command other than a tick gives its result on the next cycle
  a_quick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i != CMD_TICK) |=> valid_o)
    else $error("missing result after single cycle command");

  // a drop flag only comes from an append
  a_status_append : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (!status_o || $past(command_i) == CMD_APPEND))
    else $error("drop flag on a command other than append");

  // scan never runs while the sequence is stopped
  a_scan_running : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK || state_q == S_TEST) |-> run_q)
    else $error("list scan while not running");

endmodule

`default_nettype wire
